FILE: rtl/core/horizon_row_span_generator_defines.svh
// assertion macros for the horizon row span generator
// no dependencies; included by the top level only
`ifndef HORIZON_ROW_SPAN_GENERATOR_DEFINES_SVH
`define HORIZON_ROW_SPAN_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HRSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define HRSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/hrsg_pkg.sv
// shared constants, types and helper functions of the horizon row span generator
// no dependencies; imported by every module and used by the interfaces of the block
`timescale 1ns / 1ps

package hrsg_pkg;

   localparam int SCREEN_WIDTH = 640;

   localparam int ROW_W      = 9;
   localparam int SPAN_W     = 10;
   localparam int COLOR_W    = 8;
   localparam int TRIG_W     = 16;
   localparam int CY_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // d = 16*row - cy, then d*cos fits 32 bits signed for every input
   localparam int D_W  = ROW_W + 8;
   localparam int DC_W = 32;
   localparam int X_W  = DC_W + 1;

   localparam int HALF_THICK_Q4  = 40;
   localparam int HALF_THICK_Q18 = 655360;
   localparam int LAST_COL       = SCREEN_WIDTH - 1;
   localparam int BASE_Q4        = LAST_COL * 8;
   localparam int FULL_Q4        = LAST_COL * 16;

   // divider retires this many quotient bits per cycle
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_STEPS          = DC_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_SIN_ROLL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COS_ROLL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZON_CY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SKY_COLOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GROUND_COLOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COLOR    = 3'd5;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_roll;
      logic signed [TRIG_W-1:0] cos_roll;
      logic signed [CY_W-1:0]   horizon_center_y;
      logic [COLOR_W-1:0]       sky_color;
      logic [COLOR_W-1:0]       ground_color;
      logic [COLOR_W-1:0]       line_color;
   } hrsg_cfg_type;

   localparam hrsg_cfg_type CFG_RESET = '{
      sin_roll:         16'sd0,
      cos_roll:         16'sd16384,
      horizon_center_y: 16'sd3832,
      sky_color:        8'h5B,
      ground_color:     8'h10,
      line_color:       8'hFF
   };

   // one row as handed from the front to the back
   typedef struct packed {
      logic                   level;
      logic [COLOR_W-1:0]     level_color;
      logic signed [DC_W-1:0] dc;
   } hrsg_job_type;

   typedef struct packed {
      logic [SPAN_W-1:0]  first_col;
      logic [SPAN_W-1:0]  last_col;
      logic [COLOR_W-1:0] color;
   } hrsg_span_type;

   // remainder and shared dividend/quotient word of one divider lane
   typedef struct packed {
      logic [TRIG_W-1:0] rem;
      logic [DC_W-1:0]   work;
   } hrsg_div_type;

   // restoring division, DIV_BITS_PER_CYCLE quotient bits per call
   function automatic hrsg_div_type div_step(input hrsg_div_type cur,
                                             input logic [TRIG_W-1:0] dvsr);
      hrsg_div_type    r;
      logic [TRIG_W:0] sh;
      r  = cur;
      sh = '0;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         sh     = {r.rem, r.work[DC_W-1]};
         r.work = {r.work[DC_W-2:0], 1'b0};
         if (sh >= {1'b0, dvsr}) begin
            sh        = sh - {1'b0, dvsr};
            r.work[0] = 1'b1;
         end
         r.rem = sh[TRIG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [SPAN_W-1:0] clamp_col(input logic signed [X_W:0] v);
      logic [SPAN_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > (X_W+1)'(LAST_COL)) begin
         r = SPAN_W'(LAST_COL);
      end else begin
         r = v[SPAN_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/hrsg_if.sv
// handshake channels of the horizon row span generator: rows in, spans out, csr writes
// depends on hrsg_pkg
`timescale 1ns / 1ps

interface hrsg_req_if;
   logic                       valid;
   logic                       ready;
   logic [hrsg_pkg::ROW_W-1:0] row;
   modport source (output valid, output row, input ready);
   modport sink   (input valid, input row, output ready);
endinterface

interface hrsg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hrsg_pkg::SPAN_W-1:0]  span_start;
   logic [hrsg_pkg::SPAN_W-1:0]  span_end;
   logic [hrsg_pkg::COLOR_W-1:0] span_color;
   logic                         last_span;
   modport source (output valid, output span_start, output span_end,
                   output span_color, output last_span, input ready);
   modport sink   (input valid, input span_start, input span_end,
                   input span_color, input last_span, output ready);
endinterface

interface hrsg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hrsg_pkg::CSR_IDX_W-1:0]  index;
   logic [hrsg_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/horizon_row_span_generator.sv
// horizon row span generator top: csr registers, front end, job queue, span back end
// level rows (sin = 0) pass the front register, the job queue and states IDLE, EMIT;
// tilted rows pass IDLE, DIV, XPOS, PLAN and EMIT; one span leaves per cycle in EMIT
// while the receiver is ready; a new row is popped only after the last span of the
// row; the two-lane divider retires 4 quotient bits a cycle; 4 rows queue ahead
// reset: synchronous, clears all control state and loads the csr reset values
`timescale 1ns / 1ps
`include "horizon_row_span_generator_defines.svh"

module horizon_row_span_generator (
   input  logic       clock,
   input  logic       reset,
   hrsg_req_if.sink   req_chan,
   hrsg_rsp_if.source rsp_chan,
   hrsg_csr_if.sink   csr_chan
);
   import hrsg_pkg::*;

   hrsg_cfg_type cfg_ff, cfg_in;
   hrsg_job_type front_job, head_job;
   logic         q_push, q_pop, q_full, q_empty;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_SIN_ROLL:     cfg_in.sin_roll         = csr_chan.data;
            REG_COS_ROLL:     cfg_in.cos_roll         = csr_chan.data;
            REG_HORIZON_CY:   cfg_in.horizon_center_y = csr_chan.data;
            REG_SKY_COLOR:    cfg_in.sky_color        = csr_chan.data[COLOR_W-1:0];
            REG_GROUND_COLOR: cfg_in.ground_color     = csr_chan.data[COLOR_W-1:0];
            REG_LINE_COLOR:   cfg_in.line_color       = csr_chan.data[COLOR_W-1:0];
            default:          cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hrsg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .job      (front_job),
      .push     (q_push),
      .full     (q_full)
   );

   hrsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   hrsg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (head_job),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   `HRSG_ASSERT_IMPL(a_no_push_full, clock, reset, q_push, !q_full, "queue push while full")
   `HRSG_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty, "queue pop while empty")
   `HRSG_ASSERT_NEXT(a_push_lands, clock, reset, q_push && q_empty, !q_empty, "queue lost a job")
   `HRSG_ASSERT_IMPL(a_span_order, clock, reset, rsp_chan.valid, rsp_chan.span_end > rsp_chan.span_start, "span end not past start")

endmodule

FILE: rtl/core/hrsg_front.sv
// front end: takes a row word, forms d*cos and flags level rows with their colour
// depends on hrsg_pkg and hrsg_if
`timescale 1ns / 1ps

module hrsg_front (
   input  logic                  clock,
   input  logic                  reset,
   hrsg_req_if.sink              req_chan,
   input  hrsg_pkg::hrsg_cfg_type cfg,
   output hrsg_pkg::hrsg_job_type job,
   output logic                  push,
   input  logic                  full
);
   import hrsg_pkg::*;

   localparam logic signed [D_W-1:0] HALF_D = D_W'(HALF_THICK_Q4);

   logic              valid_ff, valid_in;
   logic [ROW_W-1:0]  row_ff;
   logic signed [D_W-1:0]      d;
   logic signed [D_W+TRIG_W-1:0] prod;

   assign req_chan.ready = !valid_ff || !full;
   assign push           = valid_ff && !full;

   always_comb begin
      d    = $signed({4'b0000, row_ff, 4'b0000}) - $signed({cfg.horizon_center_y[CY_W-1],
                                                           cfg.horizon_center_y});
      prod = d * cfg.cos_roll;

      job.level = (cfg.sin_roll == '0);
      job.dc    = prod[DC_W-1:0];
      if (d <= HALF_D && d >= -HALF_D) begin
         job.level_color = cfg.line_color;
      end else if (d < 0) begin
         job.level_color = cfg.sky_color;
      end else begin
         job.level_color = cfg.ground_color;
      end

      valid_in = valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         row_ff <= req_chan.row;
      end
   end

endmodule

FILE: rtl/core/hrsg_queue.sv
// short job queue between the front end and the span back end
// depends on hrsg_pkg
`timescale 1ns / 1ps

module hrsg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrsg_pkg::hrsg_job_type push_job,
   input  logic                  pop,
   output hrsg_pkg::hrsg_job_type head_job,
   output logic                  full,
   output logic                  empty
);
   import hrsg_pkg::*;

   hrsg_job_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head_job = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/hrsg_back.sv
// back end: divides both line edges by sin, plans up to three spans and emits them
// depends on hrsg_pkg and hrsg_if
`timescale 1ns / 1ps

module hrsg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hrsg_pkg::hrsg_cfg_type cfg,
   input  hrsg_pkg::hrsg_job_type job,
   input  logic                  empty,
   output logic                  pop,
   hrsg_rsp_if.source            rsp_chan
);
   import hrsg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_XPOS = 3'd2;
   localparam logic [2:0] ST_PLAN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic signed [X_W-1:0] HALF_X = X_W'(HALF_THICK_Q18);
   localparam logic signed [X_W-1:0] BASE_X = X_W'(BASE_Q4);
   localparam logic signed [X_W-1:0] FULL_X = X_W'(FULL_Q4);

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   hrsg_div_type         div1_ff, div1_in, div2_ff, div2_in;
   logic                 neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic signed [X_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   hrsg_span_type [2:0]  spans_ff, spans_in;
   logic [1:0]           nspan_ff, nspan_in;
   logic [1:0]           idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   hrsg_span_type        rsp_span_ff, rsp_span_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [TRIG_W-1:0]     s_abs;
   logic signed [DC_W-1:0] n1, n2;
   logic [DC_W-1:0]        mag1, mag2;
   logic signed [X_W-1:0]  nw1, nw2;
   logic signed [DC_W-1:0] q1, q2;
   logic signed [X_W-1:0]  x1, x2;
   logic                   out_free;
   logic                   emit_last;
   logic                   s_pos;
   logic [COLOR_W-1:0]     before_color, after_color, edge_color;
   logic [SPAN_W-1:0]      xs, xe;
   hrsg_span_type [2:0]    plan_sp;
   logic [1:0]             plan_n;
   hrsg_span_type          full_span;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.span_start = rsp_span_ff.first_col;
   assign rsp_chan.span_end   = rsp_span_ff.last_col;
   assign rsp_chan.span_color = rsp_span_ff.color;
   assign rsp_chan.last_span  = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // operands of both edge divisions
   always_comb begin
      s_abs = cfg.sin_roll[TRIG_W-1] ? TRIG_W'(-cfg.sin_roll) : cfg.sin_roll;
      nw1   = $signed({job.dc[DC_W-1], job.dc}) - HALF_X;
      nw2   = $signed({job.dc[DC_W-1], job.dc}) + HALF_X;
      n1    = nw1[DC_W-1:0];
      n2    = nw2[DC_W-1:0];
      mag1  = n1[DC_W-1] ? DC_W'(-n1) : n1;
      mag2  = n2[DC_W-1] ? DC_W'(-n2) : n2;
   end

   // signed quotients placed on the screen, then ordered
   always_comb begin
      q1 = neg1_ff ? -$signed(div1_ff.work) : $signed(div1_ff.work);
      q2 = neg2_ff ? -$signed(div2_ff.work) : $signed(div2_ff.work);
      x1 = $signed({q1[DC_W-1], q1}) + BASE_X;
      x2 = $signed({q2[DC_W-1], q2}) + BASE_X;
   end

   // span plan from the ordered edges
   always_comb begin
      s_pos        = !cfg.sin_roll[TRIG_W-1];
      before_color = s_pos ? cfg.ground_color : cfg.sky_color;
      after_color  = s_pos ? cfg.sky_color : cfg.ground_color;
      xs           = clamp_col(($signed({lo_ff[X_W-1], lo_ff}) + (X_W+1)'(15)) >>> 4);
      xe           = clamp_col($signed({hi_ff[X_W-1], hi_ff}) >>> 4);
      full_span    = '{first_col: '0, last_col: SPAN_W'(LAST_COL), color: '0};
      plan_sp      = '0;
      plan_n       = 2'd1;
      edge_color   = before_color;

      if (hi_ff < 0) begin
         edge_color = after_color;
      end else if (lo_ff > FULL_X || xe <= xs) begin
         edge_color = before_color;
      end

      plan_sp[0]       = full_span;
      plan_sp[0].color = edge_color;

      if (!(hi_ff < 0) && !(lo_ff > FULL_X) && xe > xs) begin
         plan_n = 2'd0;
         // before span only when it covers more than one column
         if (xs >= SPAN_W'(2)) begin
            plan_sp[plan_n] = '{first_col: '0, last_col: xs - 1'b1, color: before_color};
            plan_n          = plan_n + 1'b1;
         end
         plan_sp[plan_n] = '{first_col: xs, last_col: xe, color: cfg.line_color};
         plan_n          = plan_n + 1'b1;
         if (xe < SPAN_W'(LAST_COL - 1)) begin
            plan_sp[plan_n] = '{first_col: xe + 1'b1, last_col: SPAN_W'(LAST_COL),
                                color: after_color};
            plan_n          = plan_n + 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      div1_in      = div1_ff;
      div2_in      = div2_ff;
      neg1_in      = neg1_ff;
      neg2_in      = neg2_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      spans_in     = spans_ff;
      nspan_in     = nspan_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_span_in  = rsp_span_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      emit_last    = (idx_ff == nspan_ff - 2'd1);

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               idx_in = '0;
               if (job.level) begin
                  spans_in[0]       = full_span;
                  spans_in[0].color = job.level_color;
                  nspan_in          = 2'd1;
                  state_in          = ST_EMIT;
               end else begin
                  div1_in  = '{rem: '0, work: mag1};
                  div2_in  = '{rem: '0, work: mag2};
                  neg1_in  = n1[DC_W-1] ^ cfg.sin_roll[TRIG_W-1];
                  neg2_in  = n2[DC_W-1] ^ cfg.sin_roll[TRIG_W-1];
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div1_in = div_step(div1_ff, s_abs);
            div2_in = div_step(div2_ff, s_abs);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_XPOS;
            end
         end
         ST_XPOS: begin
            lo_in    = (x1 > x2) ? x2 : x1;
            hi_in    = (x1 > x2) ? x1 : x2;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            spans_in = plan_sp;
            nspan_in = plan_n;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_span_in  = spans_ff[idx_ff];
               rsp_last_in  = emit_last;
               idx_in       = idx_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         nspan_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nspan_ff     <= nspan_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div1_ff     <= div1_in;
      div2_ff     <= div2_in;
      neg1_ff     <= neg1_in;
      neg2_ff     <= neg2_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      spans_ff    <= spans_in;
      rsp_span_ff <= rsp_span_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: tb/sv/tb_top.sv
// self-checking bench for horizon_row_span_generator: random and directed rows, csr settings
// depends on hrsg_pkg and the hrsg_req_if / hrsg_rsp_if / hrsg_csr_if channel interfaces
`timescale 1ns / 1ps

module tb_top;
   import hrsg_pkg::*;

   localparam int  LAST_X       = 639;
   localparam int  QUIET_LIMIT  = 3000;
   localparam int  LONG_HOLD    = 400;
   localparam int  SETTLE_TICKS = 40;
   localparam int  HALF_Q18     = 655360;
   localparam int  HALF_Q4      = 40;

   typedef struct packed {
      logic [9:0] first_col;
      logic [9:0] last_col;
      logic [7:0] color;
      logic       last_flag;
   } span_word_type;

   logic clock;
   logic reset;

   hrsg_req_if req_bus ();
   hrsg_rsp_if rsp_bus ();
   hrsg_csr_if csr_bus ();

   horizon_row_span_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   hrsg_cfg_type  shadow_cfg;
   logic [8:0]    rows_to_send[$];
   span_word_type span_book[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_issued    = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;
   int rows_taken     = 0;
   int spans_checked  = 0;
   int settings_used  = 0;
   logic row_fired    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint col_clamp(input longint v);
      if (v < 0) return 0;
      if (v > LAST_X) return LAST_X;
      return v;
   endfunction

   function automatic void put_span(ref span_word_type row_spans[$], input longint xs,
                                    input longint xe, input logic [7:0] col);
      span_word_type w;
      if (xe > xs) begin
         w.first_col = xs[9:0];
         w.last_col  = xe[9:0];
         w.color     = col;
         w.last_flag = 1'b0;
         row_spans.push_back(w);
      end
   endfunction

   // works out the spans of one row from the current register copy
   function automatic void predict_row_spans(input logic [8:0] row);
      span_word_type row_spans[$];
      longint     d, s, c, dc, x1, x2, tmp, xs, xe;
      logic [7:0] pre_color, post_color, flat_color;
      d = longint'(row) * 16 - longint'(shadow_cfg.horizon_center_y);
      s = longint'(shadow_cfg.sin_roll);
      c = longint'(shadow_cfg.cos_roll);
      if (s == 0) begin
         if (d <= HALF_Q4 && d >= -HALF_Q4) flat_color = shadow_cfg.line_color;
         else if (d < 0) flat_color = shadow_cfg.sky_color;
         else flat_color = shadow_cfg.ground_color;
         put_span(row_spans, 0, LAST_X, flat_color);
      end else begin
         dc = d * c;
         // signed division truncates toward zero
         x1 = LAST_X * 8 + (dc - HALF_Q18) / s;
         x2 = LAST_X * 8 + (dc + HALF_Q18) / s;
         if (x1 > x2) begin
            tmp = x1;
            x1  = x2;
            x2  = tmp;
         end
         pre_color  = (s > 0) ? shadow_cfg.ground_color : shadow_cfg.sky_color;
         post_color = (s > 0) ? shadow_cfg.sky_color : shadow_cfg.ground_color;
         if (x2 < 0) begin
            put_span(row_spans, 0, LAST_X, post_color);
         end else if (x1 > LAST_X * 16) begin
            put_span(row_spans, 0, LAST_X, pre_color);
         end else begin
            xs = col_clamp((x1 + 15) >>> 4);
            xe = col_clamp(x2 >>> 4);
            if (xe <= xs) begin
               put_span(row_spans, 0, LAST_X, pre_color);
            end else begin
               if (xs > 0) put_span(row_spans, 0, xs - 1, pre_color);
               put_span(row_spans, xs, xe, shadow_cfg.line_color);
               if (xe < LAST_X) put_span(row_spans, xe + 1, LAST_X, post_color);
            end
         end
      end
      row_spans[row_spans.size()-1].last_flag = 1'b1;
      foreach (row_spans[i]) span_book.push_back(row_spans[i]);
   endfunction

   // row driver: next word goes out once the current one is taken, unless it idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.row   <= '0;
      end else if (!req_bus.valid || row_fired) begin
         if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.row   <= rows_to_send.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // span receiver with random stalls and a single long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_issued != hold_seen) begin
         hold_seen     <= hold_issued;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: check spans in order, predict each taken row
   always @(posedge clock) begin
      span_word_type want;
      row_fired <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         spans_checked <= spans_checked + 1;
         if (span_book.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected span: start %0d end %0d color %h last %b",
                        rsp_bus.span_start, rsp_bus.span_end, rsp_bus.span_color,
                        rsp_bus.last_span);
         end else begin
            want = span_book.pop_front();
            if (rsp_bus.span_start !== want.first_col || rsp_bus.span_end !== want.last_col ||
                rsp_bus.span_color !== want.color || rsp_bus.last_span !== want.last_flag) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: want %0d..%0d col %h last %b, got %0d..%0d col %h last %b",
                           want.first_col, want.last_col, want.color, want.last_flag,
                           rsp_bus.span_start, rsp_bus.span_end, rsp_bus.span_color,
                           rsp_bus.last_span);
            end
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         rows_taken <= rows_taken + 1;
         predict_row_spans(req_bus.row);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d spans still expected",
                  quiet_cycles, span_book.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_SIN_ROLL:     shadow_cfg.sin_roll = val;
         REG_COS_ROLL:     shadow_cfg.cos_roll = val;
         REG_HORIZON_CY:   shadow_cfg.horizon_center_y = val;
         REG_SKY_COLOR:    shadow_cfg.sky_color = val[7:0];
         REG_GROUND_COLOR: shadow_cfg.ground_color = val[7:0];
         REG_LINE_COLOR:   shadow_cfg.line_color = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_setting(input hrsg_cfg_type cfg);
      write_csr(REG_SIN_ROLL, cfg.sin_roll);
      write_csr(REG_COS_ROLL, cfg.cos_roll);
      write_csr(REG_HORIZON_CY, cfg.horizon_center_y);
      write_csr(REG_SKY_COLOR, {8'h00, cfg.sky_color});
      write_csr(REG_GROUND_COLOR, {8'h00, cfg.ground_color});
      write_csr(REG_LINE_COLOR, {8'h00, cfg.line_color});
      settings_used++;
   endtask

   // wait until every queued row is taken and every span has come back
   task automatic drain_rows();
      do @(posedge clock);
      while (rows_to_send.size() != 0 || req_bus.valid || span_book.size() != 0);
   endtask

   function automatic logic signed [15:0] trig_value();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // level, general tilt, shallow tilt, steep tilt and extreme settings
   function automatic hrsg_cfg_type pick_setting(input int kind);
      hrsg_cfg_type cfg;
      cfg.sin_roll         = trig_value();
      cfg.cos_roll         = trig_value();
      cfg.horizon_center_y = 16'($urandom_range(7679));
      cfg.sky_color        = 8'($urandom_range(255));
      cfg.ground_color     = 8'($urandom_range(255));
      cfg.line_color       = 8'($urandom_range(255));
      case (kind)
         0: cfg.sin_roll = '0;
         2: cfg.sin_roll = 16'($signed($urandom_range(128)) - 64);
         3: begin
            cfg.sin_roll = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            cfg.cos_roll = 16'($signed($urandom_range(2000)) - 1000);
         end
         4: begin
            cfg.sin_roll         = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            cfg.cos_roll         = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            cfg.horizon_center_y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
         default: if ($urandom_range(3) == 0) cfg.horizon_center_y = 16'($urandom());
      endcase
      if (cfg.sin_roll == 0 && kind != 0) cfg.sin_roll = 16'sd1;
      return cfg;
   endfunction

   task automatic queue_random_rows(input int count);
      repeat (count) begin
         if ($urandom_range(9) == 0) rows_to_send.push_back(9'($urandom_range(511, 480)));
         else rows_to_send.push_back(9'($urandom_range(479)));
      end
   endtask

   initial begin
      hrsg_cfg_type cfg;
      reset         = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_SIN_ROLL;
      csr_bus.data  = '0;
      shadow_cfg.sin_roll         = 16'sd0;
      shadow_cfg.cos_roll         = 16'sd16384;
      shadow_cfg.horizon_center_y = 16'sd3832;
      shadow_cfg.sky_color        = 8'd91;
      shadow_cfg.ground_color     = 8'd16;
      shadow_cfg.line_color       = 8'd255;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // level horizon from reset values: edges of the 6 pixel line, top and bottom rows
      rows_to_send.push_back(9'd0);
      rows_to_send.push_back(9'd236);
      rows_to_send.push_back(9'd237);
      rows_to_send.push_back(9'd239);
      rows_to_send.push_back(9'd242);
      rows_to_send.push_back(9'd243);
      rows_to_send.push_back(9'd479);
      rows_to_send.push_back(9'd511);
      drain_rows();

      // 45 degrees, line at the left edge: no width, dropped ground-side span, normal row
      cfg = '{16'sd16384, 16'sd16384, 16'sd5152, 8'h00, 8'hFF, 8'hAA};
      apply_setting(cfg);
      rows_to_send.push_back(9'd0);
      rows_to_send.push_back(9'd1);
      rows_to_send.push_back(9'd240);
      rows_to_send.push_back(9'd511);
      drain_rows();

      // line at the right edge: dropped after span, then a line of no width at the last column
      cfg.horizon_center_y = -16'sd5136;
      apply_setting(cfg);
      rows_to_send.push_back(9'd0);
      rows_to_send.push_back(9'd1);
      drain_rows();

      // negative sine swaps the colours
      cfg = '{-16'sd16384, -16'sd16384, 16'sd0, 8'hA5, 8'h5A, 8'h3C};
      apply_setting(cfg);
      rows_to_send.push_back(9'd0);
      rows_to_send.push_back(9'd200);
      drain_rows();

      // tiny sine puts the crossings far off either side
      cfg = '{16'sd1, 16'sd16384, 16'sd3832, 8'h81, 8'h7E, 8'hC3};
      apply_setting(cfg);
      rows_to_send.push_back(9'd0);
      rows_to_send.push_back(9'd239);
      rows_to_send.push_back(9'd479);
      drain_rows();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         for (int k = 0; k < 2; k++) begin
            apply_setting(pick_setting((2 * p + k) % 5));
            queue_random_rows(13);
            // long receiver hold-off while rows keep coming, so the input backs up
            if (p == 0 && k == 0) hold_issued++;
            drain_rows();
            queue_random_rows(14);
            drain_rows();
         end
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      $display("covered %0d rows and %0d spans over %0d csr settings",
               rows_taken, spans_checked, settings_used);
      $display("level, tilted, off-screen and clamped horizons; %0d mismatches, %0d spans left",
               mismatches, span_book.size());
      if (mismatches == 0 && span_book.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
